// ----- src/edu_pkg.sv -----
package edu_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 32;
    localparam int MAX_OUT = 5;
    localparam int LEFT_W  = $clog2(MAX_OUT + 1);

    localparam logic [CODE_W-1:0] CP_REPL      = 32'h0000_FFFD;
    localparam logic [CODE_W-1:0] CP_HI_LO     = 32'h0000_D800;
    localparam logic [CODE_W-1:0] CP_HI_HI     = 32'h0000_DBFF;
    localparam logic [CODE_W-1:0] CP_LO_LO     = 32'h0000_DC00;
    localparam logic [CODE_W-1:0] CP_LO_HI     = 32'h0000_DFFF;
    localparam logic [CODE_W-1:0] CP_SUPP_BASE = 32'h0001_0000;
    localparam logic [CODE_W-1:0] CP_LIMIT     = 32'h0011_0000;

    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
    localparam logic [BYTE_W-1:0] CH_UP_U   = 8'h55;
    localparam logic [BYTE_W-1:0] CH_LOW_X  = 8'h78;

    typedef struct packed {
        logic [3:0][BYTE_W-1:0] bytes;
        logic [2:0]             cnt;
    } t_utf8;

    // UTF-8 encoder; out-of-range code points give their low byte only
    function automatic t_utf8 utf8_encode(logic [CODE_W-1:0] c);
        t_utf8 r;
        r.bytes = '0;
        if (c < 32'h80) begin
            r.bytes[0] = c[7:0];
            r.cnt      = 3'd1;
        end else if (c < 32'h800) begin
            r.bytes[0] = {3'b110, c[10:6]};
            r.bytes[1] = {2'b10, c[5:0]};
            r.cnt      = 3'd2;
        end else if (c < CP_SUPP_BASE) begin
            r.bytes[0] = {4'b1110, c[15:12]};
            r.bytes[1] = {2'b10, c[11:6]};
            r.bytes[2] = {2'b10, c[5:0]};
            r.cnt      = 3'd3;
        end else if (c < CP_LIMIT) begin
            r.bytes[0] = {5'b11110, c[20:18]};
            r.bytes[1] = {2'b10, c[17:12]};
            r.bytes[2] = {2'b10, c[11:6]};
            r.bytes[3] = {2'b10, c[5:0]};
            r.cnt      = 3'd4;
        end else begin
            r.bytes[0] = c[7:0];
            r.cnt      = 3'd1;
        end
        return r;
    endfunction

endpackage

// ----- src/edu_if.sv -----
interface edu_in_if;
    logic                      valid;
    logic                      ready;
    logic [edu_pkg::BYTE_W-1:0] in_byte;
    logic                      in_last;

    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface edu_out_if;
    logic                      valid;
    logic                      ready;
    logic [edu_pkg::BYTE_W-1:0] out_byte;
    logic                      out_last;
    logic                      out_empty;

    modport source (output valid, out_byte, out_last, out_empty, input ready);
    modport sink   (input valid, out_byte, out_last, out_empty, output ready);
endinterface

// ----- src/escape_decode_to_utf8_core.sv -----
// Latency: the first result byte of an input beat is valid the cycle after it is accepted.
// Throughput: one input beat per cycle while each beat yields at most one byte and the output
// is not stalled; a beat that decodes to k bytes (k up to 5) holds off the next input while the
// result buffer drains one byte per cycle, as long as the output is ready.
// Reset (i_rst_n low, synchronous): decoder state idle, result buffer empty.
module escape_decode_to_utf8_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    edu_in_if.sink   i_in,
    edu_out_if.source o_out
);
    import edu_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_ESC     = 4'd1,
        M_OCT     = 4'd2,
        M_HEX2    = 4'd3,
        M_HEX4    = 4'd4,
        M_HEX8    = 4'd5,
        M_HIGH    = 4'd6,
        M_HIGH_BS = 4'd7,
        M_LOW4    = 4'd8
    } t_mode;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
        logic              hold;
    } t_fin;

    typedef struct packed {
        logic              b_en;
        logic [BYTE_W-1:0] b_byte;
        t_mode             mode;
        logic [3:0]        cnt;
        logic [CODE_W-1:0] acc;
    } t_esc;

    typedef struct packed {
        logic              b_en;
        logic [BYTE_W-1:0] b_byte;
        t_mode             mode;
        logic              drop;
    } t_fresh;

    // close a digit escape; hold means a high surrogate waits for its pair
    function automatic t_fin fin_digits(t_mode m, logic [CODE_W-1:0] v, logic [3:0] c,
                                        logic last);
        t_fin f;
        f.emit = 1'b1;
        f.code = v;
        f.hold = 1'b0;
        case (m)
            M_OCT: f.code = v;
            M_HEX2: f.code = (c == 4'd0) ? CODE_W'(CH_LOW_X) : v;
            M_HEX8: f.code = (c == 4'd0) ? CODE_W'(CH_UP_U) : v;
            M_HEX4: begin
                if (c == 4'd0) begin
                    f.code = '0;
                end else if (c != 4'd4 || (v >= CP_LO_LO && v <= CP_LO_HI)) begin
                    f.code = CP_REPL;
                end else if (v >= CP_HI_LO && v <= CP_HI_HI) begin
                    if (last) begin
                        f.code = CP_REPL;
                    end else begin
                        f.emit = 1'b0;
                        f.hold = 1'b1;
                    end
                end
            end
            default: f.emit = 1'b0;
        endcase
        return f;
    endfunction

    function automatic t_fresh fresh_byte(logic [BYTE_W-1:0] b, logic last);
        t_fresh f;
        f.b_en   = 1'b0;
        f.b_byte = b;
        f.mode   = M_IDLE;
        f.drop   = 1'b0;
        if (b == CH_NUL) begin
            f.drop = 1'b1;
        end else if (b == CH_BSLASH) begin
            if (last) f.b_en = 1'b1;
            else      f.mode = M_ESC;
        end else begin
            f.b_en = 1'b1;
        end
        return f;
    endfunction

    // digit escapes ending on this same beat produce a single byte
    function automatic t_esc escape_char(logic [BYTE_W-1:0] b, logic last);
        t_esc e;
        e.b_en   = 1'b1;
        e.b_byte = b;
        e.mode   = M_IDLE;
        e.cnt    = '0;
        e.acc    = '0;
        case (b)
            8'h6E: e.b_byte = 8'h0A;
            8'h74: e.b_byte = 8'h09;
            8'h72: e.b_byte = 8'h0D;
            8'h62: e.b_byte = 8'h08;
            8'h66: e.b_byte = 8'h0C;
            8'h76: e.b_byte = 8'h0B;
            8'h61: e.b_byte = 8'h07;
            CH_LOW_X: begin
                e.b_en = last;
                if (!last) e.mode = M_HEX2;
            end
            CH_LOW_U: begin
                e.b_en   = last;
                e.b_byte = CH_NUL;
                if (!last) e.mode = M_HEX4;
            end
            CH_UP_U: begin
                e.b_en = last;
                if (!last) e.mode = M_HEX8;
            end
            8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37: begin
                e.b_en   = last;
                e.b_byte = {5'b0, b[2:0]};
                e.cnt    = 4'd1;
                e.acc    = {29'b0, b[2:0]};
                if (!last) e.mode = M_OCT;
            end
            default: e.b_byte = b;
        endcase
        return e;
    endfunction

    t_mode             r_mode, n_mode;
    logic [3:0]        r_cnt, n_cnt;
    logic [CODE_W-1:0] r_acc, n_acc;
    logic [9:0]        r_high, n_high;
    logic              r_drop, n_drop;

    logic [BYTE_W-1:0] r_buf [MAX_OUT];
    logic [BYTE_W-1:0] n_buf [MAX_OUT];
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_last, r_empty, n_empty;

    logic              in_fire, out_fire;
    logic [BYTE_W-1:0] b;
    logic              last;

    logic              is_hex, is_oct, dig_ok;
    logic [3:0]        hex_d, dig, lim, cnt_inc;
    logic [CODE_W-1:0] acc_sh;

    t_fin              fin;
    t_esc              esc;
    t_fresh            frs;
    logic              a_en, b_en;
    logic [CODE_W-1:0] a_code;
    logic [BYTE_W-1:0] b_byte;
    t_utf8             enc;
    logic [2:0]        a_cnt;
    logic [LEFT_W-1:0] total;

    assign b        = i_in.in_byte;
    assign last     = i_in.in_last;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    // input may enter when the buffer is empty or hands out its last byte now
    assign i_in.ready      = (r_left == '0) || (r_left == LEFT_W'(1) && o_out.ready);
    assign o_out.valid     = (r_left != '0);
    assign o_out.out_byte  = r_buf[0];
    assign o_out.out_last  = r_last && (r_left == LEFT_W'(1));
    assign o_out.out_empty = r_empty;

    always_comb begin
        is_oct = (b >= 8'h30 && b <= 8'h37);
        is_hex = 1'b0;
        hex_d  = b[3:0];
        if (b >= 8'h30 && b <= 8'h39) begin
            is_hex = 1'b1;
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            is_hex = 1'b1;
            hex_d  = b[3:0] + 4'd9;
        end
        case (r_mode)
            M_OCT:          lim = 4'd3;
            M_HEX2:         lim = 4'd2;
            M_HEX4, M_LOW4: lim = 4'd4;
            M_HEX8:         lim = 4'd8;
            default:        lim = 4'd0;
        endcase
        dig_ok  = (r_mode == M_OCT) ? is_oct : is_hex;
        dig     = (r_mode == M_OCT) ? {1'b0, b[2:0]} : hex_d;
        acc_sh  = (r_mode == M_OCT) ? {r_acc[CODE_W-4:0], dig[2:0]}
                                    : {r_acc[CODE_W-5:0], dig};
        cnt_inc = r_cnt + 4'd1;
    end

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_high = r_high;
        n_drop = r_drop;
        a_en   = 1'b0;
        a_code = '0;
        b_en   = 1'b0;
        b_byte = b;
        fin    = '0;
        esc    = '0;
        frs    = '0;
        if (!r_drop) begin
            case (r_mode)
                M_ESC: begin
                    esc    = escape_char(b, last);
                    b_en   = esc.b_en;
                    b_byte = esc.b_byte;
                    n_mode = esc.mode;
                    n_cnt  = esc.cnt;
                    n_acc  = esc.acc;
                end
                M_OCT, M_HEX2, M_HEX4, M_HEX8: begin
                    if (dig_ok && r_cnt < lim) begin
                        n_acc = acc_sh;
                        n_cnt = cnt_inc;
                        if (cnt_inc == lim || last) begin
                            fin    = fin_digits(r_mode, acc_sh, cnt_inc, last);
                            a_en   = fin.emit;
                            a_code = fin.code;
                            n_mode = fin.hold ? M_HIGH : M_IDLE;
                            if (fin.hold) n_high = acc_sh[9:0];
                        end
                    end else begin
                        // a non-digit byte closes the escape early: the byte restarts decode
                        fin    = fin_digits(r_mode, r_acc, r_cnt, 1'b0);
                        a_en   = fin.emit;
                        a_code = fin.code;
                        frs    = fresh_byte(b, last);
                        b_en   = frs.b_en;
                        b_byte = frs.b_byte;
                        n_mode = frs.mode;
                        n_drop = frs.drop;
                    end
                end
                M_HIGH: begin
                    if (b == CH_BSLASH && !last) begin
                        n_mode = M_HIGH_BS;
                    end else begin
                        a_en   = 1'b1;
                        a_code = CP_REPL;
                        frs    = fresh_byte(b, last);
                        b_en   = frs.b_en;
                        b_byte = frs.b_byte;
                        n_mode = frs.mode;
                        n_drop = frs.drop;
                    end
                end
                M_HIGH_BS: begin
                    if (b == CH_LOW_U && !last) begin
                        n_mode = M_LOW4;
                        n_cnt  = '0;
                        n_acc  = '0;
                    end else begin
                        a_en   = 1'b1;
                        a_code = CP_REPL;
                        esc    = escape_char(b, last);
                        b_en   = esc.b_en;
                        b_byte = esc.b_byte;
                        n_mode = esc.mode;
                        n_cnt  = esc.cnt;
                        n_acc  = esc.acc;
                    end
                end
                M_LOW4: begin
                    if (is_hex && r_cnt < lim) begin
                        n_acc = acc_sh;
                        n_cnt = cnt_inc;
                        if (cnt_inc == lim) begin
                            n_mode = M_IDLE;
                            a_en   = 1'b1;
                            if (acc_sh >= CP_LO_LO && acc_sh <= CP_LO_HI) begin
                                a_code = CP_SUPP_BASE + {12'b0, r_high, acc_sh[9:0]};
                            end else begin
                                a_code = CP_REPL;
                            end
                        end else if (last) begin
                            n_mode = M_IDLE;
                            a_en   = 1'b1;
                            a_code = CP_REPL;
                        end
                    end else begin
                        a_en   = 1'b1;
                        a_code = CP_REPL;
                        frs    = fresh_byte(b, last);
                        b_en   = frs.b_en;
                        b_byte = frs.b_byte;
                        n_mode = frs.mode;
                        n_drop = frs.drop;
                    end
                end
                default: begin
                    frs    = fresh_byte(b, last);
                    b_en   = frs.b_en;
                    b_byte = frs.b_byte;
                    n_mode = frs.mode;
                    n_drop = frs.drop;
                end
            endcase
        end
        if (last) begin
            n_mode = M_IDLE;
            n_cnt  = '0;
            n_acc  = '0;
            n_high = '0;
            n_drop = 1'b0;
        end
    end

    // result assembly: encoded code point bytes, then the trailing byte if any, or a NUL empty marker
    always_comb begin
        enc     = utf8_encode(a_code);
        a_cnt   = a_en ? enc.cnt : 3'd0;
        total   = LEFT_W'(a_cnt) + LEFT_W'(b_en);
        n_empty = 1'b0;
        for (int i = 0; i < MAX_OUT; i++) begin
            if (i < 4 && 3'(i) < a_cnt) n_buf[i] = enc.bytes[i];
            else                        n_buf[i] = b_byte;
        end
        if (last && total == '0) begin
            total    = LEFT_W'(1);
            n_buf[0] = CH_NUL;
            n_empty  = 1'b1;
        end
        n_left = r_left;
        if (in_fire)       n_left = total;
        else if (out_fire) n_left = r_left - LEFT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_high <= '0;
            r_drop <= 1'b0;
            r_left <= '0;
        end else begin
            r_left <= n_left;
            if (in_fire) begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_acc  <= n_acc;
                r_high <= n_high;
                r_drop <= n_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_buf   <= n_buf;
            r_last  <= last;
            r_empty <= n_empty;
        end else if (out_fire) begin
            for (int i = 0; i < MAX_OUT - 1; i++) r_buf[i] <= r_buf[i + 1];
        end
    end

endmodule

// ----- src/edu_checker.sv -----
module edu_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_in_last,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [edu_pkg::BYTE_W-1:0] i_out_byte,
    input logic                      i_out_last,
    input logic                      i_out_empty
);
    import edu_pkg::*;

    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last) && $stable(i_out_empty))
        else $error("output beat changed while stalled");

    // an empty marker is always the closing beat of a string and carries no byte
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_empty |-> i_out_last && i_out_byte == '0)
        else $error("empty marker malformed");

    // the final input byte always produces at least one result beat
    a_last_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> i_out_valid)
        else $error("no result after final input byte");

    // input is held off while a result beat is stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted while output stalled");

endmodule

bind escape_decode_to_utf8_core edu_checker u_edu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.in_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last),
    .i_out_empty (o_out.out_empty)
);
